### rtl/core/pdsc_pkg.sv
package pdsc_pkg;

    localparam logic [7:0]  SYNC_A_BYTE   = 8'h02;
    localparam logic [7:0]  SYNC_B_BYTE   = 8'hFD;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] MAXPAY_RESET  = 16'd2048;

    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAXPAY  = 2'd2;

    // Input operation codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Frame end status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef enum logic [3:0] {
        ST_SYNC_A = 4'd0,
        ST_SYNC_B = 4'd1,
        ST_TYPE   = 4'd2,
        ST_CMD_LO = 4'd3,
        ST_CMD_HI = 4'd4,
        ST_ERR_LO = 4'd5,
        ST_ERR_HI = 4'd6,
        ST_LEN_LO = 4'd7,
        ST_LEN_HI = 4'd8,
        ST_BODY   = 4'd9,
        ST_SUM    = 4'd10
    } parse_state_t;

    typedef struct packed {
        logic        enable;
        logic        reopen;
        logic [15:0] timeout_ticks;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  frame_type;
        logic [15:0] command;
        logic [15:0] error_field;
        logic [15:0] frame_length;
        logic [1:0]  status;
    } result_t;

endpackage

### rtl/core/pdsc_cfg.sv
module pdsc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data,
    output pdsc_pkg::cfg_t                    cfg
);
    import pdsc_pkg::*;

    logic        enable_reg;
    logic [15:0] timeout_reg;
    logic [15:0] maxpay_reg;
    logic        enable_next;
    logic [15:0] timeout_next;
    logic [15:0] maxpay_next;
    logic        write;

    assign cfg_ready = 1'b1;
    assign write     = cfg_valid && cfg_ready;

    always_comb
    begin
        enable_next  = enable_reg;
        timeout_next = timeout_reg;
        maxpay_next  = maxpay_reg;
        if (write)
        begin
            case (cfg_index)
                CFG_ENABLE:  enable_next  = cfg_data[0];
                CFG_TIMEOUT: timeout_next = cfg_data;
                CFG_MAXPAY:  maxpay_next  = cfg_data;
                default:     enable_next  = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
            maxpay_reg  <= MAXPAY_RESET;
        end
        else
        begin
            enable_reg  <= enable_next;
            timeout_reg <= timeout_next;
            maxpay_reg  <= maxpay_next;
        end
    end

    // Opening a closed channel sends the parser back to hunting for a frame.
    assign cfg.reopen        = write && (cfg_index == CFG_ENABLE) && cfg_data[0] && !enable_reg;
    assign cfg.enable        = enable_reg;
    assign cfg.timeout_ticks = timeout_reg;
    assign cfg.max_payload   = maxpay_reg;

endmodule

### rtl/core/pdsc_parser.sv
module pdsc_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  pdsc_pkg::cfg_t     cfg,
    input  logic               step,
    input  logic               op,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    output pdsc_pkg::result_t  res
);
    import pdsc_pkg::*;

    parse_state_t state_reg, state_next, cur_state;
    logic [7:0]   sum_reg, sum_next;
    logic [15:0]  count_reg, count_next;
    logic [15:0]  length_reg, length_next;
    logic [7:0]   type_reg, type_next;
    logic [15:0]  command_reg, command_next;
    logic [15:0]  error_reg, error_next;
    logic [15:0]  idle_reg, idle_next;
    logic [15:0]  len_full;
    logic [15:0]  count_inc;
    logic [7:0]   sum_add;
    logic [7:0]   expected_sum;

    assign len_full     = {rx_byte, length_reg[7:0]};
    assign count_inc    = count_reg + 16'd1;
    assign sum_add      = sum_reg + rx_byte;
    assign expected_sum = 8'd0 - sum_reg;

    always_comb
    begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        type_next    = type_reg;
        command_next = command_reg;
        error_next   = error_reg;
        idle_next    = idle_reg;
        cur_state    = state_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (step)
        begin
            if (op == OP_TICK)
            begin
                if (idle_reg != 16'hFFFF)
                begin
                    idle_next = idle_reg + 16'd1;
                end
            end
            else if (cfg.enable)
            begin
                // A byte after a long pause restarts the hunt for a frame.
                if (idle_reg >= cfg.timeout_ticks)
                begin
                    cur_state = ST_SYNC_A;
                end
                idle_next = '0;

                case (cur_state)
                    ST_SYNC_B:
                    begin
                        if (rx_byte == SYNC_B_BYTE)
                        begin
                            sum_next   = sum_add;
                            state_next = ST_TYPE;
                        end
                        else
                        begin
                            state_next = ST_SYNC_A;
                        end
                    end
                    ST_TYPE:
                    begin
                        type_next  = rx_byte;
                        sum_next   = sum_add;
                        state_next = ST_CMD_LO;
                    end
                    ST_CMD_LO:
                    begin
                        command_next = {8'd0, rx_byte};
                        sum_next     = sum_add;
                        state_next   = ST_CMD_HI;
                    end
                    ST_CMD_HI:
                    begin
                        command_next = {rx_byte, command_reg[7:0]};
                        sum_next     = sum_add;
                        state_next   = ST_ERR_LO;
                    end
                    ST_ERR_LO:
                    begin
                        error_next = {8'd0, rx_byte};
                        sum_next   = sum_add;
                        state_next = ST_ERR_HI;
                    end
                    ST_ERR_HI:
                    begin
                        error_next = {rx_byte, error_reg[7:0]};
                        sum_next   = sum_add;
                        state_next = ST_LEN_LO;
                    end
                    ST_LEN_LO:
                    begin
                        length_next = {8'd0, rx_byte};
                        sum_next    = sum_add;
                        state_next  = ST_LEN_HI;
                    end
                    ST_LEN_HI:
                    begin
                        length_next = len_full;
                        sum_next    = sum_add;
                        if (len_full == 16'd0)
                        begin
                            state_next = ST_SUM;
                        end
                        else if (len_full <= cfg.max_payload)
                        begin
                            count_next = '0;
                            state_next = ST_BODY;
                        end
                        else
                        begin
                            // An oversized frame is reported at once; no checksum follows.
                            res_valid  = 1'b1;
                            res.kind   = KIND_REPORT;
                            res.status = STATUS_TOO_LONG;
                            state_next = ST_SYNC_A;
                        end
                    end
                    ST_BODY:
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = rx_byte;
                        res.byte_index   = count_reg;
                        sum_next         = sum_add;
                        count_next       = count_inc;
                        if (count_inc == length_reg)
                        begin
                            state_next = ST_SUM;
                        end
                    end
                    ST_SUM:
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_REPORT;
                        res.status = (expected_sum == rx_byte) ? STATUS_OK : STATUS_BAD_SUM;
                        state_next = ST_SYNC_A;
                    end
                    default:
                    begin
                        if (rx_byte == SYNC_A_BYTE)
                        begin
                            sum_next   = rx_byte;
                            state_next = ST_SYNC_B;
                        end
                        else
                        begin
                            state_next = ST_SYNC_A;
                        end
                    end
                endcase
            end
        end

        res.frame_type   = type_next;
        res.command      = command_next;
        res.error_field  = error_next;
        res.frame_length = length_next;

        if (cfg.reopen)
        begin
            state_next = ST_SYNC_A;
            idle_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SYNC_A;
            sum_reg     <= '0;
            count_reg   <= '0;
            length_reg  <= '0;
            type_reg    <= '0;
            command_reg <= '0;
            error_reg   <= '0;
            idle_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            type_reg    <= type_next;
            command_reg <= command_next;
            error_reg   <= error_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

### rtl/core/packet_deframer_sum_check.sv
// Receive-side frame parser for a byte link.
// Input channel (in_valid / in_stall): each transaction is either a received
// byte (op low, rx_byte) or one time tick (op high). Output channel
// (out_valid / out_stall): a payload byte (kind low) with its index in the
// frame, or a frame end report (kind high) with the header fields and a
// status of ok, checksum mismatch or length above max_payload.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes enable,
// timeout_ticks and max_payload; write it only while the block is idle.
// One transaction is taken every cycle unless in_stall is high. A transaction
// accepted into the input register is processed by the parser when the result
// register is free, and its result is captured in the result register. The
// rate is set by the combinational parser update between the input register
// and the result register. When the receiver stalls a valid result, that
// register holds and the input register keeps the next transaction; in_stall
// is high while both registers are full and out_stall is high.
// Reset closes the channel, restores the register defaults, empties both
// registers and sends the parser to hunting for the first start byte.
module packet_deframer_sum_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kind,
    output logic [7:0]                        payload_byte,
    output logic [15:0]                       byte_index,
    output logic [7:0]                        frame_type,
    output logic [15:0]                       command,
    output logic [15:0]                       error_field,
    output logic [15:0]                       frame_length,
    output logic [1:0]                        status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data
);
    import pdsc_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_res_reg;
    logic    res_valid;
    logic    s1_valid_reg, s1_valid_next;
    logic    s1_op_reg;
    logic    [7:0] s1_byte_reg;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;
    logic    step;
    logic    in_take;

    pdsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdsc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .op        (s1_op_reg),
        .rx_byte   (s1_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = step && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg   <= op;
            s1_byte_reg <= rx_byte;
        end
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_res_reg.kind;
    assign payload_byte = out_res_reg.payload_byte;
    assign byte_index   = out_res_reg.byte_index;
    assign frame_type   = out_res_reg.frame_type;
    assign command      = out_res_reg.command;
    assign error_field  = out_res_reg.error_field;
    assign frame_length = out_res_reg.frame_length;
    assign status       = out_res_reg.status;

`ifndef SYNTHESIS
    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_REPORT) |-> (payload_byte == 8'd0) && (byte_index == 16'd0)
            && (status != 2'd3))
        else $error("frame end report carries payload data or a bad status");

    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PAYLOAD) |-> (status == STATUS_OK))
        else $error("payload byte carries a non-zero status");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled without a waiting transaction");

    a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && s1_valid_reg |=> in_stall || !out_stall)
        else $error("input register advanced into a stalled result register");
`endif

endmodule
